[hw/rtl/wsdf_pkg.sv]
// Shared types for the WebSocket frame deframer.
// Defines the queue entry passed from the header parser to the output stage.
// No dependencies.
package wsdf_pkg;

    // One result word as it travels through the queue, still masked.
    typedef struct packed {
        logic [7:0] raw_byte;
        logic [7:0] key_byte;
        logic [3:0] opcode;
        logic       fin;
        logic       first;
        logic       last;
        logic       empty;
    } t_entry;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

endpackage

[hw/rtl/websocket_frame_deframer.sv]
// WebSocket (RFC 6455) receive-side frame deframer, top level.
// Instantiates wsdf_front, wsdf_queue and wsdf_back; uses wsdf_pkg.
//
// Usage:
//   The slave stream s_axis takes the received byte stream, one byte per
//   word. Header, extended-length and mask-key bytes are consumed without
//   output. Each payload byte leaves on m_axis unmasked, tagged with the
//   frame's opcode and FIN bit, first_of_frame on the first byte and tlast
//   on the last one. A frame with zero payload gives one marker word with
//   payload 0 and first, last and empty all set.
//   Throughput: one byte per cycle while the queue has room, set by the
//   parser's state update and 64-bit length countdown. A payload byte
//   accepted at a clock edge is written to the queue at that edge and is
//   then loaded into the output register and presented on m_axis.
//   A stalled receiver fills the output register and then the queue of
//   QUEUE_DEPTH words; s_axis_tready drops only when the queue is full.
//   Reset (i_rst_n low, synchronous) returns the parser to waiting for a
//   first header byte and empties the queue and output register.
module websocket_frame_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic       m_axis_tlast,   // last_of_frame
    output logic [6:0] m_axis_tuser    // [3:0] frame_opcode, [4] final_fragment,
                                       // [5] first_of_frame, [6] empty_frame
);
    import wsdf_pkg::*;

    logic   q_ready, q_push, q_valid, q_pop;
    t_entry push_entry, head_entry;

    wsdf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_ready     (q_ready),
        .o_q_push      (q_push),
        .o_q_entry     (push_entry)
    );

    wsdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    wsdf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_entry     (head_entry),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[hw/rtl/wsdf_front.sv]
// Header parser of the WebSocket frame deframer: takes one byte per word,
// tracks the frame header and pushes one tagged result per payload byte
// and one marker word per empty frame. Depends on wsdf_pkg.
module wsdf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                i_q_ready,
    output logic                o_q_push,
    output wsdf_pkg::t_entry    o_q_entry
);
    import wsdf_pkg::*;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]  r_phase,   n_phase;
    logic [3:0]  r_opcode,  n_opcode;
    logic        r_fin,     n_fin;
    logic        r_mask,    n_mask;
    logic [31:0] r_key,     n_key;
    logic [2:0]  r_cnt,     n_cnt;
    logic [63:0] r_rem,     n_rem;
    logic [1:0]  r_pidx,    n_pidx;
    logic        r_first,   n_first;

    logic        accept;
    logic [7:0]  b;
    logic [6:0]  len7;
    logic        hdr_done;
    logic [63:0] rem_chk;
    logic [7:0]  key_sel;

    assign s_axis_tready = i_q_ready;
    assign accept        = s_axis_tvalid && i_q_ready;
    assign b             = s_axis_tdata;
    assign len7          = b[6:0];

    // Key byte for the next payload byte, first key byte in bits 31..24.
    always_comb begin
        case (r_pidx)
            2'd0:    key_sel = r_key[31:24];
            2'd1:    key_sel = r_key[23:16];
            2'd2:    key_sel = r_key[15:8];
            default: key_sel = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_mask   = r_mask;
        n_key    = r_key;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_pidx   = r_pidx;
        n_first  = r_first;
        hdr_done = 1'b0;
        rem_chk  = r_rem;
        o_q_push = 1'b0;
        o_q_entry.raw_byte = b;
        o_q_entry.key_byte = r_mask ? key_sel : 8'd0;
        o_q_entry.opcode   = r_opcode;
        o_q_entry.fin      = r_fin;
        o_q_entry.first    = r_first;
        o_q_entry.last     = (r_rem == 64'd1);
        o_q_entry.empty    = 1'b0;

        if (accept) begin
            case (r_phase)
                PH_HDR1: begin
                    n_mask = b[7];
                    n_key  = 32'd0;
                    n_rem  = 64'd0;
                    if (len7 == LEN7_EXT16) begin
                        n_cnt   = 3'd1;
                        n_phase = PH_EXTLEN;
                    end else if (len7 == LEN7_EXT64) begin
                        n_cnt   = 3'd7;
                        n_phase = PH_EXTLEN;
                    end else begin
                        n_rem = {57'd0, len7};
                        if (b[7]) begin
                            n_cnt   = 3'd3;
                            n_phase = PH_MASK;
                        end else begin
                            hdr_done = 1'b1;
                            rem_chk  = {57'd0, len7};
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_rem = {r_rem[55:0], b};
                    if (r_cnt != 3'd0) begin
                        n_cnt = r_cnt - 3'd1;
                    end else if (r_mask) begin
                        n_cnt   = 3'd3;
                        n_phase = PH_MASK;
                    end else begin
                        hdr_done = 1'b1;
                        rem_chk  = {r_rem[55:0], b};
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], b};
                    if (r_cnt != 3'd0) begin
                        n_cnt = r_cnt - 3'd1;
                    end else begin
                        hdr_done = 1'b1;
                        rem_chk  = r_rem;
                    end
                end
                PH_PAYLOAD: begin
                    o_q_push = 1'b1;
                    n_pidx   = r_pidx + 2'd1;
                    n_rem    = r_rem - 64'd1;
                    n_first  = 1'b0;
                    if (r_rem == 64'd1) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_fin    = b[7];
                    n_opcode = b[3:0];
                    n_phase  = PH_HDR1;
                end
            endcase

            // Header complete: emit the empty-frame marker or start payload.
            if (hdr_done) begin
                if (rem_chk == 64'd0) begin
                    o_q_push           = 1'b1;
                    o_q_entry.raw_byte = 8'd0;
                    o_q_entry.key_byte = 8'd0;
                    o_q_entry.first    = 1'b1;
                    o_q_entry.last     = 1'b1;
                    o_q_entry.empty    = 1'b1;
                    n_first            = 1'b0;
                    n_phase            = PH_HDR0;
                end else begin
                    n_pidx  = 2'd0;
                    n_first = 1'b1;
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= 4'd0;
            r_fin    <= 1'b0;
            r_mask   <= 1'b0;
            r_key    <= 32'd0;
            r_cnt    <= 3'd0;
            r_rem    <= 64'd0;
            r_pidx   <= 2'd0;
            r_first  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_mask   <= n_mask;
            r_key    <= n_key;
            r_cnt    <= n_cnt;
            r_rem    <= n_rem;
            r_pidx   <= n_pidx;
            r_first  <= n_first;
        end
    end

endmodule

[hw/rtl/wsdf_queue.sv]
// Short FIFO of parsed result words between parser and output stage.
// Depends on wsdf_pkg for the entry type.
module wsdf_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wsdf_pkg::t_entry    i_entry,
    output logic                o_ready,
    input  logic                i_pop,
    output logic                o_valid,
    output wsdf_pkg::t_entry    o_entry
);
    import wsdf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[hw/rtl/wsdf_back.sv]
// Output stage of the WebSocket frame deframer: unmasks queued words and
// holds them in an output register for the downstream stream.
// Depends on wsdf_pkg.
module wsdf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  wsdf_pkg::t_entry    i_q_entry,
    output logic                o_q_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,  // [7:0] payload_byte
    output logic                m_axis_tlast,  // last_of_frame
    output logic [6:0]          m_axis_tuser   // [3:0] frame_opcode, [4] final_fragment,
                                               // [5] first_of_frame, [6] empty_frame
);
    import wsdf_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic [6:0] r_user;
    logic       load;

    // Refill the output register when empty or when its word is taken.
    assign load    = i_q_valid && (!r_valid || m_axis_tready);
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_q_entry.raw_byte ^ i_q_entry.key_byte;
            r_last <= i_q_entry.last;
            r_user <= {i_q_entry.empty, i_q_entry.first, i_q_entry.fin, i_q_entry.opcode};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = r_user;

endmodule

[verif/websocket_frame_deframer_test.sv]
// Testbench for websocket_frame_deframer: streams WebSocket frames in byte by byte and
// compares every output word with a cycle-free model of the header parser and unmasking.
// Depends on wsdf_pkg (length codes) and the deframer RTL.
module websocket_frame_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wsdf_pkg::*;

    typedef enum logic [2:0] {
        HDR_FIRST  = 3'd0,
        HDR_LENGTH = 3'd1,
        EXT_LENGTH = 3'd2,
        KEY_BYTES  = 3'd3,
        PAYLOAD    = 3'd4
    } t_parse_phase;

    typedef enum int {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } t_len_form;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] opcode;
        logic       fin;
        logic       first;
        logic       last;
        logic       empty;
    } t_deframed_word;

    class t_deframe_scoreboard;
        t_parse_phase   phase;
        logic [3:0]     opcode;
        logic           fin;
        logic           masked;
        logic [31:0]    key;
        logic [2:0]     hdr_left;
        logic [63:0]    remain;
        logic [1:0]     key_idx;
        logic           first_due;
        t_deframed_word expected_q[$];
        int             errors;

        function new();
            phase     = HDR_FIRST;
            opcode    = '0;
            fin       = 1'b0;
            masked    = 1'b0;
            key       = '0;
            hdr_left  = '0;
            remain    = '0;
            key_idx   = '0;
            first_due = 1'b0;
            errors    = 0;
        endfunction

        function void report_mismatch(string msg);
            $display("ERROR at %0t ns: %s", $realtime, msg);
            errors++;
        endfunction

        // Length (and key) complete: open the payload or emit the empty-frame marker.
        function void close_header();
            t_deframed_word w;
            if (remain == 64'd0) begin
                w = '{data: 8'h00, opcode: opcode, fin: fin, first: 1'b1, last: 1'b1,
                      empty: 1'b1};
                expected_q.insert(expected_q.size(), w);
                first_due = 1'b0;
                phase = HDR_FIRST;
            end else begin
                key_idx = '0;
                first_due = 1'b1;
                phase = PAYLOAD;
            end
        endfunction

        function void note_byte(logic [7:0] b);
            t_deframed_word w;
            logic [7:0]     v;
            case (phase)
                HDR_LENGTH: begin
                    masked = b[7];
                    key = '0;
                    remain = '0;
                    if (b[6:0] == LEN7_EXT16) begin
                        hdr_left = 3'd1;
                        phase = EXT_LENGTH;
                    end else if (b[6:0] == LEN7_EXT64) begin
                        hdr_left = 3'd7;
                        phase = EXT_LENGTH;
                    end else begin
                        remain = {57'd0, b[6:0]};
                        if (masked) begin
                            hdr_left = 3'd3;
                            phase = KEY_BYTES;
                        end else begin
                            close_header();
                        end
                    end
                end
                EXT_LENGTH: begin
                    remain = {remain[55:0], b};
                    if (hdr_left != 3'd0) begin
                        hdr_left--;
                    end else if (masked) begin
                        hdr_left = 3'd3;
                        phase = KEY_BYTES;
                    end else begin
                        close_header();
                    end
                end
                KEY_BYTES: begin
                    key = {key[23:0], b};
                    if (hdr_left != 3'd0)
                        hdr_left--;
                    else
                        close_header();
                end
                PAYLOAD: begin
                    v = b;
                    // key byte 0 sits in bits 31..24
                    if (masked)
                        v = b ^ 8'(key >> (8 * (3 - int'(key_idx))));
                    key_idx++;
                    remain--;
                    w = '{data: v, opcode: opcode, fin: fin, first: first_due,
                          last: (remain == 64'd0), empty: 1'b0};
                    expected_q.insert(expected_q.size(), w);
                    first_due = 1'b0;
                    if (remain == 64'd0)
                        phase = HDR_FIRST;
                end
                default: begin
                    fin = b[7];
                    opcode = b[3:0];
                    phase = HDR_LENGTH;
                end
            endcase
        endfunction

        function void check_word(t_deframed_word got);
            t_deframed_word exp_w;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word data=%02h user=%b",
                                          got.data, got));
                return;
            end
            exp_w = expected_q[0];
            expected_q.delete(0);
            if (got.data !== exp_w.data)
                report_mismatch($sformatf("payload byte %02h, expected %02h",
                                          got.data, exp_w.data));
            if (got.opcode !== exp_w.opcode)
                report_mismatch($sformatf("opcode %0h, expected %0h",
                                          got.opcode, exp_w.opcode));
            if (got.fin !== exp_w.fin)
                report_mismatch($sformatf("fin %b, expected %b", got.fin, exp_w.fin));
            if (got.first !== exp_w.first)
                report_mismatch($sformatf("first_of_frame %b, expected %b",
                                          got.first, exp_w.first));
            if (got.last !== exp_w.last)
                report_mismatch($sformatf("tlast %b, expected %b", got.last, exp_w.last));
            if (got.empty !== exp_w.empty)
                report_mismatch($sformatf("empty_frame %b, expected %b",
                                          got.empty, exp_w.empty));
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] payload_byte
    logic       m_axis_tlast;           // last_of_frame
    logic [6:0] m_axis_tuser;           // [3:0] frame_opcode, [4] final_fragment,
                                        // [5] first_of_frame, [6] empty_frame

    t_deframe_scoreboard sb = new();
    int                  bytes_sent = 0;
    int                  burst_left = 0;
    int                  stall_mode = 0;
    int                  mode_left = 0;
    logic [31:0]         tick = '0;

    websocket_frame_deframer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: switch between always ready, coin flip, sparse and long stalls.
    always @(posedge i_clk) begin
        tick <= tick + 32'd1;
        if (mode_left == 0) begin
            stall_mode <= int'($urandom_range(0, 3));
            mode_left <= int'($urandom_range(64, 256));
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (tick[3:0] < 4'd3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word('{data: m_axis_tdata, opcode: m_axis_tuser[3:0],
                            fin: m_axis_tuser[4], first: m_axis_tuser[5],
                            last: m_axis_tlast, empty: m_axis_tuser[6]});
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            burst_left = int'($urandom_range(1, 24));
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Send header, length, key and count payload bytes (count < length leaves it open).
    task automatic send_frame(input logic [7:0] head, input logic masked,
                              input logic [63:0] length, input t_len_form form,
                              input logic [31:0] key, input int count);
        logic [6:0] len7;
        len7 = (form == LEN_SHORT) ? length[6:0] :
               (form == LEN_EXT16) ? LEN7_EXT16 : LEN7_EXT64;
        send_byte(head);
        send_byte({masked, len7});
        if (form == LEN_EXT16) begin
            send_byte(length[15:8]);
            send_byte(length[7:0]);
        end else if (form == LEN_EXT64) begin
            for (int i = 7; i >= 0; i--)
                send_byte(8'(length >> (8 * i)));
        end
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_byte(8'(key >> (8 * i)));
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int          kind;
        int          guard;
        logic [63:0] len;
        logic        msk;
        logic [7:0]  head;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty text frame, empty masked frame with reserved bits set,
        // masked payload wrapping the key, 16-bit length close frame.
        send_frame(8'h81, 1'b0, 64'd0, LEN_SHORT, 32'h0, 0);
        send_frame(8'h7F, 1'b1, 64'd0, LEN_SHORT, 32'hFF00_A55A, 0);
        send_frame(8'h02, 1'b1, 64'd5, LEN_SHORT, 32'h5A00_FFC3, 5);
        send_frame(8'h88, 1'b0, 64'd1, LEN_EXT16, 32'h0, 1);

        // hold off until the output side has drained
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);

        while (bytes_sent < 2000) begin
            kind = int'($urandom_range(0, 99));
            msk = 1'($urandom_range(0, 1));
            head = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 0) begin
                // the opcodes in common use
                case ($urandom_range(0, 5))
                    0: head[3:0] = 4'h0;
                    1: head[3:0] = 4'h1;
                    2: head[3:0] = 4'h2;
                    3: head[3:0] = 4'h8;
                    4: head[3:0] = 4'h9;
                    default: head[3:0] = 4'hA;
                endcase
            end
            if (kind < 70) begin
                len = 64'($urandom_range(0, 12));
                send_frame(head, msk, len, LEN_SHORT, $urandom, int'(len));
            end else if (kind < 82) begin
                len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 400))
                                                   : 64'($urandom_range(0, 60));
                send_frame(head, msk, len, LEN_EXT16, $urandom, int'(len));
            end else if (kind < 90) begin
                len = 64'($urandom_range(0, 30));
                send_frame(head, msk, len, LEN_EXT64, $urandom, int'(len));
            end else begin
                len = 64'($urandom_range(0, 125));
                send_frame(head, msk, len, LEN_SHORT, $urandom, int'(len));
            end
        end

        // largest 64-bit length: stream a few bytes, the frame never closes
        send_frame(8'h82, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, LEN_EXT64, $urandom, 6);

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (sb.expected_q.size() != 0 && guard < 100_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d expected words never arrived",
                                         sb.expected_q.size()));
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
